[rtl/core/dcs_pkg.sv]
// dcs_pkg: shared types and constants of the distinct-key counter.
// No dependencies; imported by every module in rtl/core but dcs_ram.
package dcs_pkg;

    localparam int DEF_PRECISION      = 14;
    localparam int DEF_EXACT_CAPACITY = 1024;
    localparam int KEY_W              = 64;
    localparam int RANK_W             = 6;
    localparam int EST_W              = 48;
    localparam int QDEPTH             = 2;

    localparam logic [63:0] XP1 = 64'h9E37_79B1_85EB_CA87;
    localparam logic [63:0] XP2 = 64'hC2B2_AE3D_27D4_EB4F;
    localparam logic [63:0] XP3 = 64'h1656_67B1_9E37_79F9;
    localparam logic [63:0] XP4 = 64'h85EB_CA77_C2B2_AE63;
    localparam logic [63:0] XP5 = 64'h27D4_EB2F_1656_67C5;
    localparam logic [63:0] ACC0_A = 64'h1_2345_6789 + XP5 + 64'd8;
    localparam logic [63:0] ACC0_B = 64'h9_8765_4321 + XP5 + 64'd8;
    localparam logic [31:0] LN2_Q32 = 32'hB172_17F7;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_ESTIMATE = 2'd1,
        CMD_CLEAR    = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [KEY_W-1:0]  key;
    } dcs_item_t;

    typedef struct packed {
        logic clearing;
    } dcs_status_t;

endpackage

[rtl/core/distinct_count_sketch.sv]
// Distinct-key counter: exact set, then a 2^PRECISION-register sketch.
// Insert in exact mode probes the set in order; sketch insert hashes the key,
// finds its rank (capped at 64-PRECISION) and does a read-modify-write; estimate
// returns the set size in exact mode, or in sketch mode walks the registers,
// divides and, for small estimates, takes a 28-step log. One item at a time.
// Reset: clears all the sketch registers; no beat taken meanwhile.
module distinct_count_sketch
    import dcs_pkg::*;
#(
    parameter int PRECISION      = DEF_PRECISION,
    parameter int EXACT_CAPACITY = DEF_EXACT_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // estimate_q16
    output logic [0:0]  m_tuser    // exact_flag
);

    logic        q_valid;
    dcs_item_t   q_item;
    logic        q_pop;
    dcs_status_t status;

    dcs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .status   (status),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    dcs_back #(
        .PRECISION      (PRECISION),
        .EXACT_CAPACITY (EXACT_CAPACITY)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/core/dcs_ram.sv]
// dcs_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module dcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/dcs_front.sv]
// dcs_front: input beat acceptance, command classification and a short queue.
// Depends on dcs_pkg.
module dcs_front
    import dcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key
    input  logic [1:0]  s_tuser,   // command
    input  dcs_status_t status,
    output logic        q_valid,
    output dcs_item_t   q_item,
    input  logic        q_pop
);

    localparam int QAW = $clog2(QDEPTH);

    dcs_item_t       q_mem_reg [QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg;
    logic [QAW-1:0]  rd_ptr_reg;
    logic [QAW:0]    count_reg;
    logic            push;
    logic            pop;
    cmd_t            cmd;

    assign cmd      = cmd_t'(s_tuser);
    assign s_tready = (count_reg < (QAW+1)'(QDEPTH)) && !status.clearing;
    assign push     = s_tvalid && s_tready && (cmd != CMD_NONE);
    assign pop      = q_pop && q_valid;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                q_mem_reg[wr_ptr_reg] <= '{cmd: cmd, key: s_tdata};
                wr_ptr_reg            <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QAW+1)'(QDEPTH))
        else $error("queue overfilled");

    a_no_take_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !push)
        else $error("beat taken during clearing pass");

endmodule

[rtl/core/dcs_hash.sv]
// dcs_hash: iterative dual-seed 64-bit key hash on one 32x32 multiplier.
// Depends on dcs_pkg.
module dcs_hash
    import dcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] key,
    output logic        done,
    output logic [63:0] hash
);

    typedef enum logic [2:0] {H_IDLE, H_T, H_K, H_A1, H_A2, H_A3} hstate_t;

    hstate_t     state_reg;
    logic [1:0]  phase_reg;
    logic        seed_reg;
    logic [63:0] x_reg;
    logic [63:0] prod_reg;
    logic [63:0] k_reg;
    logic [63:0] ha_reg;
    logic [63:0] hash_reg;
    logic        done_reg;

    logic [63:0] cst;
    logic [31:0] mul_x;
    logic [31:0] mul_c;
    logic [63:0] mp;
    logic [63:0] a1;
    logic [63:0] a1x;
    logic [63:0] a2x;
    logic [63:0] a3x;
    logic [63:0] kx;
    logic [63:0] bx;

    always_comb
    begin
        case (state_reg)
            H_T:     cst = XP2;
            H_K:     cst = XP1;
            H_A1:    cst = XP1;
            H_A2:    cst = XP2;
            H_A3:    cst = XP3;
            default: cst = XP1;
        endcase
        mul_x = (phase_reg == 2'd1) ? x_reg[63:32] : x_reg[31:0];
        mul_c = (phase_reg == 2'd2) ? cst[63:32]   : cst[31:0];
    end

    assign mp  = mul_x * mul_c;
    assign a1  = prod_reg + XP4;
    assign a1x = a1 ^ (a1 >> 33);
    assign a2x = prod_reg ^ (prod_reg >> 29);
    assign a3x = prod_reg ^ (prod_reg >> 32);
    assign kx  = ACC0_A ^ prod_reg;
    assign bx  = ACC0_B ^ k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            phase_reg <= '0;
            seed_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (state_reg == H_IDLE)
            begin
                if (start)
                begin
                    x_reg     <= key;
                    phase_reg <= '0;
                    seed_reg  <= 1'b0;
                    state_reg <= H_T;
                end
            end
            else
            begin
                phase_reg <= phase_reg + 1'b1;
                case (phase_reg)
                    2'd0: prod_reg <= mp;
                    2'd1, 2'd2: prod_reg <= prod_reg + {mp[31:0], 32'h0};
                    default:
                    begin
                        case (state_reg)
                            H_T:
                            begin
                                x_reg     <= {prod_reg[32:0], prod_reg[63:33]};
                                state_reg <= H_K;
                            end
                            H_K:
                            begin
                                k_reg     <= prod_reg;
                                x_reg     <= {kx[36:0], kx[63:37]};
                                state_reg <= H_A1;
                            end
                            H_A1:
                            begin
                                x_reg     <= a1x;
                                state_reg <= H_A2;
                            end
                            H_A2:
                            begin
                                x_reg     <= a2x;
                                state_reg <= H_A3;
                            end
                            H_A3:
                            begin
                                if (!seed_reg)
                                begin
                                    ha_reg    <= a3x;
                                    x_reg     <= {bx[36:0], bx[63:37]};
                                    seed_reg  <= 1'b1;
                                    state_reg <= H_A1;
                                end
                                else
                                begin
                                    hash_reg  <= ha_reg ^ (a3x >> 1);
                                    done_reg  <= 1'b1;
                                    state_reg <= H_IDLE;
                                end
                            end
                            default: state_reg <= H_IDLE;
                        endcase
                    end
                endcase
            end
        end
    end

    assign done = done_reg;
    assign hash = hash_reg;

endmodule

[rtl/core/dcs_div.sv]
// dcs_div: 128-by-64 restoring divider, one quotient bit per cycle, saturating.
// Depends on dcs_pkg.
module dcs_div
    import dcs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] num,
    input  logic [63:0]  den,
    output logic         done,
    output logic [63:0]  quo
);

    typedef enum logic {D_IDLE, D_RUN} dstate_t;

    dstate_t     state_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] rem_reg;
    logic [63:0] lo_reg;
    logic [63:0] q_reg;
    logic [63:0] den_reg;
    logic        done_reg;
    logic [63:0] rem_sh;
    logic        take;

    assign rem_sh = {rem_reg[62:0], lo_reg[63]};
    assign take   = rem_reg[63] || (rem_sh >= den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        den_reg <= den;
                        rem_reg <= num[127:64];
                        lo_reg  <= num[63:0];
                        q_reg   <= '0;
                        cnt_reg <= '0;
                        if (num[127:64] >= den)
                        begin
                            q_reg    <= '1;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN:
                begin
                    lo_reg  <= {lo_reg[62:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (take)
                    begin
                        rem_reg <= rem_sh - den_reg;
                        q_reg   <= {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        q_reg   <= {q_reg[62:0], 1'b0};
                    end
                    if (cnt_reg == 6'd63)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

[rtl/core/dcs_back.sv]
// dcs_back: exact-set probing, sketch update, estimate walk and result register.
// Depends on dcs_pkg, dcs_ram, dcs_hash, dcs_div.
module dcs_back
    import dcs_pkg::*;
#(
    parameter int PRECISION      = DEF_PRECISION,
    parameter int EXACT_CAPACITY = DEF_EXACT_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  dcs_item_t   q_item,
    output logic        q_pop,
    output dcs_status_t status,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // estimate_q16
    output logic [0:0]  m_tuser    // exact_flag
);

    localparam int EX_AW = $clog2(EXACT_CAPACITY);
    localparam int EX_SW = $clog2(EXACT_CAPACITY + 1);
    localparam int NREGS = 1 << PRECISION;
    localparam logic [PRECISION:0] NUM_REGS_C = {1'b1, {PRECISION{1'b0}}};
    localparam logic [EX_SW-1:0] EX_CAP_C = EX_SW'(EXACT_CAPACITY);
    localparam logic [63:0] NUM_REGS64 = 64'd1 << PRECISION;
    localparam logic [63:0] ALPHA_Q32 =
        (PRECISION == 4) ? (64'd673 << 32) / 64'd1000 :
        (PRECISION == 5) ? (64'd697 << 32) / 64'd1000 :
        (PRECISION == 6) ? (64'd709 << 32) / 64'd1000 :
        ((64'd7213 * NUM_REGS64) << 32) / (64'd10 * (64'd1000 * NUM_REGS64 + 64'd1079));
    localparam logic [127:0] E_NUM = {64'h0, ALPHA_Q32} << (48 + PRECISION);
    localparam logic [127:0] H_NUM = 128'd1 << (3 * PRECISION + 16);
    localparam logic [63:0] SMALL_THR = (64'd5 * NUM_REGS64) << 16;
    localparam logic [63:0] LARGE_THR = (64'd1 << 48) / 64'd30;
    localparam logic [63:0] ONE_Q16 = 64'd65536;
    localparam logic [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;
    localparam int LN_SH = 44 - PRECISION;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(64 - PRECISION);
    localparam logic [6:0] S_BASE = 7'(64 - PRECISION);

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE, ST_PROBE, ST_HASH, ST_RANK, ST_RRD, ST_RWB,
        ST_WALK, ST_DIV_E, ST_CHK, ST_NORM, ST_SQ, ST_LN, ST_LNSH,
        ST_DIV_H, ST_FIN, ST_OUT
    } bstate_t;

    bstate_t               state_reg;
    logic [EX_SW-1:0]      exact_size_reg;
    logic                  exact_mode_reg;
    logic [PRECISION:0]    wcnt_reg;
    logic [EX_SW-1:0]      pcnt_reg;
    logic                  rv_reg;
    logic [63:0]           key_reg;
    logic [PRECISION-1:0]  idx_reg;
    logic [63:0]           v_reg;
    logic [RANK_W-1:0]     rank_reg;
    logic [PRECISION:0]    zeros_reg;
    logic [63:0]           s_reg;
    logic [63:0]           hsum_reg;
    logic [63:0]           e_reg;
    logic [31:0]           y_reg;
    logic [4:0]            ip_reg;
    logic [27:0]           frac_reg;
    logic [4:0]            sq_cnt_reg;
    logic [63:0]           prod_reg;
    logic                  m_tvalid_reg;
    logic [47:0]           m_tdata_reg;
    logic                  m_tuser_reg;
    logic [47:0]           res_data_reg;
    logic                  res_flag_reg;

    logic                  idle_take;
    logic                  probe_issue;
    logic                  probe_hit;
    logic                  probe_miss;
    logic                  room;
    logic                  walk_issue;
    logic                  walk_end;
    logic                  hash_start;
    logic [63:0]           hash_key;
    logic                  hash_done;
    logic [63:0]           hash_val;
    logic                  div_start;
    logic [127:0]          div_num;
    logic [63:0]           div_den;
    logic                  div_done;
    logic [63:0]           div_quo;
    logic                  ex_we;
    logic                  ex_re;
    logic [EX_AW-1:0]      ex_waddr;
    logic [EX_AW-1:0]      ex_raddr;
    logic [63:0]           ex_rdata;
    logic                  rk_we;
    logic                  rk_re;
    logic [PRECISION-1:0]  rk_waddr;
    logic [PRECISION-1:0]  rk_raddr;
    logic [RANK_W-1:0]     rk_wdata;
    logic [RANK_W-1:0]     rk_rdata;
    logic [63:0]           s_term;
    logic [63:0]           h_term;
    logic [64:0]           h_add;
    logic [32:0]           l_val;
    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic [63:0]           mul_p;
    logic [32:0]           sq_t;
    logic [63:0]           e_fin;

    assign idle_take   = (state_reg == ST_IDLE) && q_valid;
    assign q_pop       = idle_take;
    assign probe_issue = pcnt_reg < exact_size_reg;
    assign probe_hit   = (state_reg == ST_PROBE) && rv_reg && (ex_rdata == key_reg);
    assign probe_miss  = (state_reg == ST_PROBE) && !probe_issue && !rv_reg;
    assign room        = exact_size_reg < EX_CAP_C;
    assign walk_issue  = wcnt_reg < NUM_REGS_C;
    assign walk_end    = (state_reg == ST_WALK) && !walk_issue && !rv_reg;

    assign hash_start = (idle_take && (q_item.cmd == CMD_INSERT) && !exact_mode_reg)
                     || (probe_miss && !room);
    assign hash_key   = (state_reg == ST_IDLE) ? q_item.key : key_reg;

    assign div_start = (walk_end && (zeros_reg != NUM_REGS_C))
                    || ((state_reg == ST_CHK) && (e_reg > SMALL_THR) && (e_reg > LARGE_THR));
    assign div_num   = (state_reg == ST_CHK) ? H_NUM : E_NUM;
    assign div_den   = (state_reg == ST_CHK) ? hsum_reg : s_reg;

    assign ex_we    = probe_miss && room;
    assign ex_waddr = exact_size_reg[EX_AW-1:0];
    assign ex_re    = (state_reg == ST_PROBE) && probe_issue;
    assign ex_raddr = pcnt_reg[EX_AW-1:0];

    assign rk_we    = (state_reg == ST_CLR) || ((state_reg == ST_RWB) && (rk_rdata < rank_reg));
    assign rk_waddr = (state_reg == ST_CLR) ? wcnt_reg[PRECISION-1:0] : idx_reg;
    assign rk_wdata = (state_reg == ST_CLR) ? '0 : rank_reg;
    assign rk_re    = (state_reg == ST_RRD) || ((state_reg == ST_WALK) && walk_issue);
    assign rk_raddr = (state_reg == ST_WALK) ? wcnt_reg[PRECISION-1:0] : idx_reg;

    assign s_term = 64'd1 << (S_BASE - {1'b0, rk_rdata});
    assign h_term = 64'd1 << rk_rdata;
    assign h_add  = {1'b0, hsum_reg} + {1'b0, h_term};

    assign l_val = (33'(PRECISION) << 28) - {ip_reg, frac_reg};
    assign mul_a = (state_reg == ST_SQ) ? y_reg : l_val[31:0];
    assign mul_b = (state_reg == ST_SQ) ? y_reg : LN2_Q32;
    assign mul_p = mul_a * mul_b;
    assign sq_t  = mul_p[63:31];
    assign e_fin = (e_reg < ONE_Q16) ? ONE_Q16 : ((e_reg > MAX48) ? MAX48 : e_reg);

    dcs_ram #(.WIDTH(64), .DEPTH(EXACT_CAPACITY)) u_exact_ram (
        .clk   (clk),
        .we    (ex_we),
        .waddr (ex_waddr),
        .wdata (key_reg),
        .re    (ex_re),
        .raddr (ex_raddr),
        .rdata (ex_rdata)
    );

    dcs_ram #(.WIDTH(RANK_W), .DEPTH(NREGS)) u_rank_ram (
        .clk   (clk),
        .we    (rk_we),
        .waddr (rk_waddr),
        .wdata (rk_wdata),
        .re    (rk_re),
        .raddr (rk_raddr),
        .rdata (rk_rdata)
    );

    dcs_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (hash_key),
        .done  (hash_done),
        .hash  (hash_val)
    );

    dcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            exact_size_reg <= '0;
            exact_mode_reg <= 1'b1;
            wcnt_reg       <= '0;
            pcnt_reg       <= '0;
            rv_reg         <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLR:
                begin
                    wcnt_reg <= wcnt_reg + 1'b1;
                    if (wcnt_reg == NUM_REGS_C - 1'b1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        key_reg  <= q_item.key;
                        pcnt_reg <= '0;
                        wcnt_reg <= '0;
                        rv_reg   <= 1'b0;
                        case (q_item.cmd)
                            CMD_INSERT:
                                state_reg <= exact_mode_reg ? ST_PROBE : ST_HASH;
                            CMD_ESTIMATE:
                            begin
                                if (exact_mode_reg)
                                begin
                                    res_data_reg <= 48'({exact_size_reg, 16'h0});
                                    res_flag_reg <= 1'b1;
                                    state_reg    <= ST_OUT;
                                end
                                else
                                begin
                                    zeros_reg <= '0;
                                    s_reg     <= '0;
                                    hsum_reg  <= '0;
                                    state_reg <= ST_WALK;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                exact_size_reg <= '0;
                                exact_mode_reg <= 1'b1;
                                state_reg      <= ST_CLR;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_PROBE:
                begin
                    if (probe_issue)
                    begin
                        pcnt_reg <= pcnt_reg + 1'b1;
                    end
                    rv_reg <= probe_issue;
                    if (probe_hit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (probe_miss)
                    begin
                        if (room)
                        begin
                            exact_size_reg <= exact_size_reg + 1'b1;
                            state_reg      <= ST_IDLE;
                        end
                        else
                        begin
                            exact_size_reg <= '0;
                            exact_mode_reg <= 1'b0;
                            state_reg      <= ST_HASH;
                        end
                    end
                end
                ST_HASH:
                begin
                    if (hash_done)
                    begin
                        idx_reg   <= hash_val[63 -: PRECISION];
                        v_reg     <= hash_val | (64'd1 << (64 - PRECISION));
                        rank_reg  <= RANK_W'(1);
                        state_reg <= ST_RANK;
                    end
                end
                ST_RANK:
                begin
                    if (v_reg[0] || (rank_reg == RANK_MAX))
                    begin
                        state_reg <= ST_RRD;
                    end
                    else
                    begin
                        v_reg    <= v_reg >> 1;
                        rank_reg <= rank_reg + 1'b1;
                    end
                end
                ST_RRD: state_reg <= ST_RWB;
                ST_RWB: state_reg <= ST_IDLE;
                ST_WALK:
                begin
                    if (walk_issue)
                    begin
                        wcnt_reg <= wcnt_reg + 1'b1;
                    end
                    rv_reg <= walk_issue;
                    if (rv_reg)
                    begin
                        if (rk_rdata == '0)
                        begin
                            zeros_reg <= zeros_reg + 1'b1;
                        end
                        s_reg    <= s_reg + s_term;
                        hsum_reg <= h_add[64] ? '1 : h_add[63:0];
                    end
                    if (walk_end)
                    begin
                        if (zeros_reg == NUM_REGS_C)
                        begin
                            e_reg     <= ONE_Q16;
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            state_reg <= ST_DIV_E;
                        end
                    end
                end
                ST_DIV_E:
                begin
                    if (div_done)
                    begin
                        e_reg     <= div_quo;
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK:
                begin
                    if (e_reg <= SMALL_THR)
                    begin
                        if (zeros_reg != '0)
                        begin
                            y_reg     <= 32'(zeros_reg);
                            ip_reg    <= 5'd31;
                            state_reg <= ST_NORM;
                        end
                        else
                        begin
                            state_reg <= ST_FIN;
                        end
                    end
                    else if (e_reg > LARGE_THR)
                    begin
                        state_reg <= ST_DIV_H;
                    end
                    else
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_NORM:
                begin
                    if (y_reg[31])
                    begin
                        frac_reg   <= '0;
                        sq_cnt_reg <= '0;
                        state_reg  <= ST_SQ;
                    end
                    else
                    begin
                        y_reg  <= {y_reg[30:0], 1'b0};
                        ip_reg <= ip_reg - 1'b1;
                    end
                end
                ST_SQ:
                begin
                    if (sq_t[32])
                    begin
                        y_reg    <= sq_t[32:1];
                        frac_reg <= {frac_reg[26:0], 1'b1};
                    end
                    else
                    begin
                        y_reg    <= sq_t[31:0];
                        frac_reg <= {frac_reg[26:0], 1'b0};
                    end
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == 5'd27)
                    begin
                        state_reg <= ST_LN;
                    end
                end
                ST_LN:
                begin
                    prod_reg  <= mul_p + (l_val[32] ? {LN2_Q32, 32'h0} : 64'h0);
                    state_reg <= ST_LNSH;
                end
                ST_LNSH:
                begin
                    e_reg     <= prod_reg >> LN_SH;
                    state_reg <= ST_FIN;
                end
                ST_DIV_H:
                begin
                    if (div_done)
                    begin
                        if (div_quo < e_reg)
                        begin
                            e_reg <= div_quo;
                        end
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    res_data_reg <= e_fin[47:0];
                    res_flag_reg <= 1'b0;
                    state_reg    <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_data_reg;
                        m_tuser_reg  <= res_flag_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign status.clearing = (state_reg == ST_CLR);
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign m_tuser         = m_tuser_reg;

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        exact_size_reg <= EX_CAP_C)
        else $error("exact set overfilled");

    a_sketch_empty_set: assert property (@(posedge clk) disable iff (!rst_n)
        !exact_mode_reg |-> (exact_size_reg == '0))
        else $error("exact set not empty in sketch mode");

    a_hash_expected: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> (state_reg == ST_HASH))
        else $error("unexpected hash completion");

    a_div_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_E || state_reg == ST_DIV_H))
        else $error("unexpected divide completion");

endmodule

[verif/distinct_count_sketch_test.sv]
// Self-checking testbench for distinct_count_sketch: exact set, overflow into the sketch,
// estimates, clears and ignored commands, with random idling on both stream sides.
// Depends on rtl/core/dcs_pkg.sv and rtl/core/distinct_count_sketch.sv.
`timescale 1ns / 100ps

module distinct_count_sketch_test;
    import dcs_pkg::*;

    localparam int P        = DEF_PRECISION;
    localparam int NREG     = 1 << P;
    localparam int CAP      = DEF_EXACT_CAPACITY;
    localparam int WD_LIMIT = 120000;

    typedef struct packed {
        logic [47:0] est;
        logic        exact;
    } estimate_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // key
    logic [1:0]  s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // estimate_q16
    logic [0:0]  m_tuser;   // exact_flag

    distinct_count_sketch i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // predictor state
    logic [5:0]  ranks [NREG];
    logic [63:0] set_keys [CAP];
    int          set_size;
    logic        set_mode;

    estimate_t   pending_estimates[$];
    logic [63:0] seen_keys[$];
    int          src_idle;
    int          snk_idle;
    int          mismatches;
    int          idle_cycles;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [63:0] rotl(logic [63:0] x, int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] xxh64_key(logic [63:0] v, logic [63:0] acc0);
        logic [63:0] acc;
        acc = acc0 ^ (rotl(v * XP2, 31) * XP1);
        acc = rotl(acc, 27) * XP1 + XP4;
        acc = acc ^ (acc >> 33);
        acc = acc * XP2;
        acc = acc ^ (acc >> 29);
        acc = acc * XP3;
        acc = acc ^ (acc >> 32);
        return acc;
    endfunction

    function automatic logic [63:0] div_sat(logic [127:0] num, logic [63:0] d);
        logic [127:0] q;
        q = num / {64'd0, d};
        return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    function automatic logic [63:0] log2_q28(int z);
        int          ip;
        logic [63:0] y;
        logic [63:0] frac;
        ip = 0;
        frac = 0;
        while (ip < 31 && (z >> (ip + 1)) != 0)
            ip++;
        y = 64'(z) << (31 - ip);
        for (int i = 0; i < 28; i++)
        begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= 64'h1_0000_0000)
            begin
                y = y >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(ip) << 28) | frac;
    endfunction

    function automatic void sketch_update(logic [63:0] key);
        logic [63:0] h;
        logic [63:0] v;
        int          rnk;
        int          idx;
        h = xxh64_key(key, ACC0_A) ^ (xxh64_key(key, ACC0_B) >> 1);
        idx = int'(h >> (64 - P));
        v = h | (64'd1 << (64 - P));
        rnk = 1;
        while (!v[rnk-1])
            rnk++;
        if (rnk > 64 - P)
            rnk = 64 - P;
        if (ranks[idx] < rnk)
            ranks[idx] = 6'(rnk);
    endfunction

    function automatic logic [47:0] sketch_cardinality();
        logic [63:0]  s;
        logic [64:0]  hsum;
        logic [63:0]  e;
        logic [63:0]  alpha;
        logic [63:0]  l;
        int           zeros;
        s = 0;
        hsum = 0;
        zeros = 0;
        for (int i = 0; i < NREG; i++)
        begin
            if (ranks[i] == 0)
                zeros++;
            s = s + (64'd1 << (64 - P - ranks[i]));
            hsum = hsum + (65'd1 << ranks[i]);
            if (hsum[64])
                hsum = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
        end
        if (zeros == NREG || s == 0)
            return 48'h1_0000;
        alpha = ((64'd7213 * NREG) << 32) / (64'd10 * (64'd1000 * NREG + 64'd1079));
        e = div_sat(128'(alpha) << (48 + P), s);
        if (e <= (64'(5 * NREG) << 16))
        begin
            if (zeros > 0)
            begin
                l = (64'(P) << 28) - log2_q28(zeros);
                e = (l * 64'(LN2_Q32)) >> (44 - P);
            end
        end
        else if (e > (64'd1 << 48) / 30)
        begin
            logic [63:0] he;
            he = div_sat(128'd1 << (3 * P + 16), hsum[63:0]);
            if (he < e)
                e = he;
        end
        if (e < 64'h1_0000)
            e = 64'h1_0000;
        if (e > 64'hFFFF_FFFF_FFFF)
            e = 64'hFFFF_FFFF_FFFF;
        return e[47:0];
    endfunction

    function automatic void counter_reset();
        foreach (ranks[i])
            ranks[i] = '0;
        set_size = 0;
        set_mode = 1'b1;
    endfunction

    function automatic void predict_beat(cmd_t cmd, logic [63:0] key);
        estimate_t want;
        case (cmd)
            CMD_INSERT:
            begin
                if (set_mode)
                begin
                    for (int i = 0; i < set_size; i++)
                        if (set_keys[i] == key)
                            return;
                    if (set_size < CAP)
                    begin
                        set_keys[set_size] = key;
                        set_size++;
                        return;
                    end
                    set_size = 0;
                    set_mode = 1'b0;
                end
                sketch_update(key);
            end
            CMD_ESTIMATE:
            begin
                want.exact = set_mode;
                if (set_mode)
                    want.est = 48'(set_size) << 16;
                else
                    want.est = sketch_cardinality();
                pending_estimates.insert(pending_estimates.size(), want);
            end
            CMD_CLEAR:
                counter_reset();
            default: ;
        endcase
    endfunction

    task automatic send_beat(cmd_t cmd, logic [63:0] key);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= key;
        do
            @(posedge clk);
        while (!s_tready);
        predict_beat(cmd, key);
        if (cmd == CMD_INSERT)
            seen_keys.insert(seen_keys.size(), key);
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] old_key();
        if (seen_keys.size() == 0)
            return 64'd0;
        return seen_keys[$urandom_range(seen_keys.size() - 1)];
    endfunction

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= snk_idle);

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            estimate_t want;
            if (pending_estimates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: est=%h exact=%b", m_tdata, m_tuser);
            end
            else
            begin
                want = pending_estimates.pop_front();
                if (m_tdata !== want.est || m_tuser[0] !== want.exact)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: est exp %h got %h, exact exp %b got %b",
                                 want.est, m_tdata, want.exact, m_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_exact_basics();
        send_beat(CMD_ESTIMATE, 64'd0);
        send_beat(CMD_INSERT, 64'd0);
        send_beat(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(CMD_INSERT, 64'd0);
        send_beat(CMD_INSERT, 64'h8000_0000_0000_0001);
        send_beat(CMD_ESTIMATE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(CMD_NONE, 64'h1234_5678_9ABC_DEF0);
        send_beat(CMD_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(CMD_ESTIMATE, 64'd0);
        send_beat(CMD_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(CMD_ESTIMATE, 64'd0);
        send_beat(CMD_INSERT, 64'h5555_5555_5555_5555);
        send_beat(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_beat(CMD_ESTIMATE, 64'd0);
    endtask

    // fill the set right up to capacity, then overflow into the sketch
    task automatic test_set_overflow();
        while (set_size < CAP)
        begin
            if ($urandom_range(9) == 0)
                send_beat(CMD_INSERT, old_key());
            else
                send_beat(CMD_INSERT, rand_key());
            if ($urandom_range(199) == 0)
                send_beat(CMD_ESTIMATE, rand_key());
        end
        send_beat(CMD_ESTIMATE, 64'd0);
        send_beat(CMD_INSERT, old_key());
        send_beat(CMD_ESTIMATE, 64'd0);
        send_beat(CMD_INSERT, rand_key());
        send_beat(CMD_ESTIMATE, 64'd0);
        send_beat(CMD_INSERT, old_key());
        send_beat(CMD_ESTIMATE, 64'd0);
    endtask

    task automatic test_sketch_random(int n);
        for (int i = 0; i < n; i++)
        begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 2)
                send_beat(CMD_ESTIMATE, rand_key());
            else if (pick < 5)
                send_beat(CMD_NONE, rand_key());
            else if (pick < 20)
                send_beat(CMD_INSERT, old_key());
            else
                send_beat(CMD_INSERT, rand_key());
        end
        send_beat(CMD_ESTIMATE, 64'd0);
    endtask

    task automatic test_clear_restart();
        send_beat(CMD_CLEAR, rand_key());
        send_beat(CMD_ESTIMATE, 64'd0);
        for (int i = 0; i < 120; i++)
        begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 8)
                send_beat(CMD_ESTIMATE, rand_key());
            else if (pick < 12)
                send_beat(CMD_NONE, rand_key());
            else if (pick < 30)
                send_beat(CMD_INSERT, old_key());
            else
                send_beat(CMD_INSERT, rand_key());
        end
        send_beat(CMD_ESTIMATE, 64'd0);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CMD_INSERT;
        m_tready    = 1'b0;
        mismatches  = 0;
        idle_cycles = 0;
        src_idle    = 6;
        snk_idle    = 76;
        counter_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_exact_basics();
        test_set_overflow();
        src_idle = 76;
        snk_idle = 6;
        test_sketch_random(300);
        src_idle = 0;
        snk_idle = 0;
        test_sketch_random(300);
        test_clear_restart();

        s_tvalid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
